>>> hw/rtl/ops_pkg.sv
`timescale 1ns / 1ps

package ops_pkg;

	// Fixed field widths
	localparam int unsigned ODD_W  = 17;
	localparam int unsigned QIDX_W = 16;
	localparam int unsigned CNT_W  = 17;

	// Configuration port
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;

	// Register indexes, taken from paddr[2]
	localparam logic REG_ODD_COUNT = 1'b0;

	localparam logic [ODD_W-1:0] ODD_COUNT_RST = ODD_W'(50000);

	// Request codes
	localparam logic REQ_RUN   = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

endpackage

>>> hw/rtl/ops_if.sv
`timescale 1ns / 1ps

// Request channel
interface ops_in_if;
	import ops_pkg::*;

	logic              valid;
	logic              ready;
	logic              req_type;
	logic [QIDX_W-1:0] query_index;

	modport source (output valid, output req_type, output query_index, input ready);
	modport sink (input valid, input req_type, input query_index, output ready);
endinterface

// Result channel
interface ops_out_if;
	import ops_pkg::*;

	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] prime_count;
	logic             is_prime;

	modport source (output valid, output prime_count, output is_prime, input ready);
	modport sink (input valid, input prime_count, input is_prime, output ready);
endinterface

>>> hw/rtl/ops_cfg.sv
`timescale 1ns / 1ps

module ops_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ops_pkg::ADDR_W-1:0] paddr,
	input  logic [ops_pkg::DATA_W-1:0] pwdata,
	output logic [ops_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output logic [ops_pkg::ODD_W-1:0]  odd_count
);
	import ops_pkg::*;

	logic [ODD_W-1:0] odd_count_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// Hold the range register; writes to other indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			odd_count_q <= ODD_COUNT_RST;
		end else if (wr_en && paddr[2] == REG_ODD_COUNT) begin
			odd_count_q <= pwdata[ODD_W-1:0];
		end
	end

	// Read back
	always_comb begin
		if (paddr[2] == REG_ODD_COUNT) begin
			prdata = DATA_W'(odd_count_q);
		end else begin
			prdata = '0;
		end
	end

	assign odd_count = odd_count_q;

endmodule

>>> hw/rtl/ops_engine.sv
`timescale 1ns / 1ps

module ops_engine #(
	parameter int unsigned MAX_ODD_ENTRIES = 65536
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [ops_pkg::ODD_W-1:0] odd_count,
	ops_in_if.sink                    req,
	ops_out_if.source                 rsp
);
	import ops_pkg::*;

	localparam int unsigned AW = $clog2(MAX_ODD_ENTRIES);
	localparam int unsigned NW = AW + 1;
	localparam int unsigned SW = AW + 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_OUTER,
		ST_TEST,
		ST_MARK,
		ST_COUNT,
		ST_FINISH,
		ST_QUERY
	} state_t;

	state_t            state_q;
	logic [NW-1:0]     n_q;
	logic [NW-1:0]     limit_q;
	logic [NW-1:0]     i_q;
	logic [AW-1:0]     k_q;
	logic [SW-1:0]     p_q;
	logic [SW-1:0]     s0_q;
	logic [SW-1:0]     ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  last_count_q;
	logic              rd_v_s1;
	logic              hit_q;
	logic              out_valid_q;
	logic [CNT_W-1:0]  out_count_q;
	logic              out_prime_q;

	logic [NW-1:0]     n_sat;
	logic              accept;
	logic              q_in_range;
	logic [AW-1:0]     raddr;
	logic              we;
	logic [AW-1:0]     waddr;
	logic              wdata;
	logic              rdata_q;
	logic [SW-1:0]     s0_next;

	// Bitmap: one bit per odd candidate, 1 = composite
	logic mem [MAX_ODD_ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// Clamp the range to the bitmap size
	assign n_sat = (32'(odd_count) > 32'(MAX_ODD_ENTRIES)) ?
		NW'(MAX_ODD_ENTRIES) : NW'(odd_count);

	assign accept     = req.valid & req.ready;
	assign req.ready  = (state_q == ST_IDLE) & (~out_valid_q | rsp.ready);
	assign q_in_range = 32'(req.query_index) < 32'(limit_q);

	// Start of the next prime's marks: s(k+1) = s(k) + 2p + 2
	assign s0_next = s0_q + {p_q[SW-2:0], 1'b0} + SW'(2);

	// Memory port selection
	always_comb begin
		we    = 1'b0;
		waddr = i_q[AW-1:0];
		wdata = 1'b0;
		raddr = i_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				raddr = AW'(req.query_index);
			end
			ST_CLEAR: begin
				we = (i_q != n_q);
			end
			ST_OUTER: begin
				raddr = k_q;
			end
			ST_MARK: begin
				we    = (ptr_q < SW'(n_q));
				waddr = ptr_q[AW-1:0];
				wdata = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer: clear, sieve, count, or answer a query
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			n_q          <= '0;
			limit_q      <= '0;
			i_q          <= '0;
			k_q          <= '0;
			p_q          <= '0;
			s0_q         <= '0;
			ptr_q        <= '0;
			cnt_q        <= '0;
			last_count_q <= '0;
			rd_v_s1      <= 1'b0;
			hit_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			out_count_q  <= '0;
			out_prime_q  <= 1'b0;
		end else begin
			// Retire the result on transfer
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.req_type == REQ_RUN) begin
							n_q     <= n_sat;
							i_q     <= '0;
							state_q <= ST_CLEAR;
						end else begin
							hit_q   <= q_in_range;
							state_q <= ST_QUERY;
						end
					end
				end
				ST_CLEAR: begin
					if (i_q == n_q) begin
						k_q     <= '0;
						p_q     <= SW'(3);
						s0_q    <= SW'(3);
						state_q <= ST_OUTER;
					end else begin
						i_q <= i_q + NW'(1);
					end
				end
				ST_OUTER: begin
					if (s0_q >= SW'(n_q)) begin
						i_q     <= '0;
						cnt_q   <= '0;
						rd_v_s1 <= 1'b0;
						state_q <= ST_COUNT;
					end else begin
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					if (!rdata_q) begin
						ptr_q   <= s0_q;
						state_q <= ST_MARK;
					end else begin
						k_q     <= k_q + AW'(1);
						p_q     <= p_q + SW'(2);
						s0_q    <= s0_next;
						state_q <= ST_OUTER;
					end
				end
				ST_MARK: begin
					if (ptr_q >= SW'(n_q)) begin
						k_q     <= k_q + AW'(1);
						p_q     <= p_q + SW'(2);
						s0_q    <= s0_next;
						state_q <= ST_OUTER;
					end else begin
						ptr_q <= ptr_q + p_q;
					end
				end
				ST_COUNT: begin
					// Count the entry read last cycle
					if (rd_v_s1 && !rdata_q) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (i_q == n_q) begin
						rd_v_s1 <= 1'b0;
						state_q <= ST_FINISH;
					end else begin
						rd_v_s1 <= 1'b1;
						i_q     <= i_q + NW'(1);
					end
				end
				ST_FINISH: begin
					// Add one for the prime 2
					last_count_q <= cnt_q + CNT_W'(1);
					limit_q      <= n_q;
					out_count_q  <= cnt_q + CNT_W'(1);
					out_prime_q  <= 1'b0;
					out_valid_q  <= 1'b1;
					state_q      <= ST_IDLE;
				end
				ST_QUERY: begin
					out_count_q <= last_count_q;
					out_prime_q <= hit_q & ~rdata_q;
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.prime_count = out_count_q;
	assign rsp.is_prime    = out_prime_q;

endmodule

>>> hw/rtl/odd_only_prime_sieve.sv
`timescale 1ns / 1ps

// Odd-only prime sieve. Bitmap entry k stands for the odd number 2k+3.
// Channels: req (sink) carries req_type and query_index; rsp (source)
// carries prime_count and is_prime, one result per request. Both use
// valid/ready and move one item per transfer. The APB port holds
// odd_count at address 0 (reset 50000), clamped to MAX_ODD_ENTRIES per run.
// A run (req_type 0) clears the bitmap over n = odd_count entries, strikes
// multiples of each unmarked prime from its square upward, then counts the
// unmarked entries and adds one for the prime 2. Its pace is set by the
// single one-write/one-read bitmap memory that every clear, test, mark and
// count step goes through.
// A query (req_type 1) does one bitmap read, then loads the result
// register. It answers from the last run; before any run it returns zero.
// The result sits in an output register; a new request is taken in idle once
// it is empty or being transferred, so a stalled receiver holds the block.
// Reset returns the block to idle with no valid run; the bitmap needs no
// clearing pass, since each run clears its own range.
module odd_only_prime_sieve #(
	parameter int unsigned MAX_ODD_ENTRIES = 65536
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ops_pkg::ADDR_W-1:0] paddr,
	input  logic [ops_pkg::DATA_W-1:0] pwdata,
	output logic [ops_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	ops_in_if.sink                     req,
	ops_out_if.source                  rsp
);
	import ops_pkg::*;

	logic [ODD_W-1:0] odd_count;

	ops_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.odd_count (odd_count)
	);

	ops_engine #(
		.MAX_ODD_ENTRIES (MAX_ODD_ENTRIES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.odd_count (odd_count),
		.req       (req),
		.rsp       (rsp)
	);

endmodule
